/* src/rmf_pkg.sv */
package rmf_pkg;

    // Fixed widths of the port fields
    localparam int CFG_DATA_W = 13;
    localparam int CFG_W_W    = 12;
    localparam int CFG_H_W    = 13;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 11;

    // Register indexes on the configuration port
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [CFG_W_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_H_W-1:0] RESET_HEIGHT = 13'd480;

    // Input action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // One BGR pixel, blue in the low byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // Per-transaction decision made when an input is accepted
    typedef struct packed {
        logic                 write;   // pixel enters line buffer and window
        logic                 emit;    // a result leaves for this transaction
        logic                 border;  // result is forced to zero
        logic                 last;    // last result of the frame
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } t_dec;

    // Sum of eight bytes divided by 8, round to nearest, ties to even
    function automatic logic [7:0] round_mean8(input logic [10:0] sum);
        logic [7:0] q;
        logic [2:0] rem;
        logic       up;
        q   = sum[10:3];
        rem = sum[2:0];
        up  = (rem > 3'd4) || ((rem == 3'd4) && q[0]);
        return q + {7'd0, up};
    endfunction

endpackage

/* src/ring_mean_3x3_filter_top.sv */
// Channel   Handshake                Payload
// config    i_cfg_we                 i_cfg_idx, i_cfg_data
// input     i_in_valid / o_in_ready  i_action, i_in_blue, i_in_green, i_in_red
// output    o_out_valid / i_out_ready o_out_blue, o_out_green, o_out_red,
//                                    o_out_row, o_out_col, o_frame_end
//
// One transaction per clock while the input is not stalled. A result passes through
// the input stage (line buffer read), then the window update and rounding
// into the output register.
// Input stalls only while the output register holds an untaken result and
// the input stage holds a transaction that emits. Synchronous active-low
// reset; line buffer contents are not cleared.
module ring_mean_3x3_filter_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [rmf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic [7:0]                        i_in_blue,
    input  logic [7:0]                        i_in_green,
    input  logic [7:0]                        i_in_red,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_out_blue,
    output logic [7:0]                        o_out_green,
    output logic [7:0]                        o_out_red,
    output logic [rmf_pkg::OUT_ROW_W-1:0]     o_out_row,
    output logic [rmf_pkg::OUT_COL_W-1:0]     o_out_col,
    output logic                              o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = $bits(rmf_pkg::t_pix);

    rmf_pkg::t_dec dec;
    logic [CW-1:0] dec_col;
    logic          accept, adv_a, fwd_hit;
    logic [2*PW-1:0] rd_data;
    rmf_pkg::t_pix rd_top, rd_mid, eff_top, eff_mid, in_pix, mean;

    // Input stage
    logic          r_a_valid;
    rmf_pkg::t_dec r_a_dec;
    logic [CW-1:0] r_a_col;
    rmf_pkg::t_pix r_a_pix;
    logic          r_a_fwd;
    rmf_pkg::t_pix r_a_fwd_top, r_a_fwd_mid;

    // Output register
    logic          r_o_valid;
    rmf_pkg::t_pix r_o_pix;
    logic [rmf_pkg::OUT_ROW_W-1:0] r_o_row;
    logic [rmf_pkg::OUT_COL_W-1:0] r_o_col;
    logic          r_o_last;

    assign in_pix.blue  = i_in_blue;
    assign in_pix.green = i_in_green;
    assign in_pix.red   = i_in_red;

    // Handshake: the input stage moves on unless its result has nowhere to go
    assign adv_a      = r_a_valid && (!r_a_dec.emit || !r_o_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || adv_a;
    assign accept     = i_in_valid && o_in_ready;

    rmf_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_action   (i_action),
        .o_dec      (dec),
        .o_col      (dec_col)
    );

    // Line buffer column read at accept, write-back when the stage moves on
    rmf_line_buf #(
        .DEPTH (MAX_WIDTH),
        .DW    (2*PW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept && dec.write),
        .i_rd_addr (dec_col),
        .o_rd_data (rd_data),
        .i_wr_en   (adv_a && r_a_dec.write),
        .i_wr_addr (r_a_col),
        .i_wr_data ({eff_mid, r_a_pix})
    );

    assign rd_top = rd_data[2*PW-1:PW];
    assign rd_mid = rd_data[PW-1:0];

    // Same column written on the accepting edge: take the data being written
    assign eff_top = r_a_fwd ? r_a_fwd_top : rd_top;
    assign eff_mid = r_a_fwd ? r_a_fwd_mid : rd_mid;
    assign fwd_hit = adv_a && r_a_dec.write && dec.write && (r_a_col == dec_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_dec     <= dec;
            r_a_col     <= dec_col;
            r_a_pix     <= in_pix;
            r_a_fwd     <= fwd_hit;
            r_a_fwd_top <= eff_mid;
            r_a_fwd_mid <= r_a_pix;
        end
    end

    rmf_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (adv_a && r_a_dec.write),
        .i_top   (eff_top),
        .i_mid   (eff_mid),
        .i_pix   (r_a_pix),
        .o_mean  (mean)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv_a && r_a_dec.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && r_a_dec.emit) begin
            r_o_pix  <= r_a_dec.border ? '0 : mean;
            r_o_row  <= r_a_dec.row;
            r_o_col  <= r_a_dec.col;
            r_o_last <= r_a_dec.last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_blue  = r_o_pix.blue;
    assign o_out_green = r_o_pix.green;
    assign o_out_red   = r_o_pix.red;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_frame_end = r_o_last;

endmodule

/* src/rmf_line_buf.sv */
module rmf_line_buf #(
    parameter int DEPTH = 2048,
    parameter int DW    = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data
);

    // Both previous rows share one word per column: {older row, newer row}
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/rmf_ctrl.sv */
module rmf_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [rmf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_accept,
    input  logic                            i_action,
    output rmf_pkg::t_dec                   o_dec,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_col
);

    localparam int CW  = $clog2(MAX_WIDTH);       // input / output column
    localparam int EW  = $clog2(MAX_WIDTH + 1);   // effective width
    localparam int RW  = $clog2(MAX_HEIGHT + 1);  // input row, may reach height
    localparam int ORW = $clog2(MAX_HEIGHT);      // output row

    logic [rmf_pkg::CFG_W_W-1:0] r_cfg_w;
    logic [rmf_pkg::CFG_H_W-1:0] r_cfg_h;
    logic [CW-1:0]  r_in_col,  n_in_col;
    logic [RW-1:0]  r_in_row,  n_in_row;
    logic [CW-1:0]  r_out_col, n_out_col;
    logic [ORW-1:0] r_out_row, n_out_row;
    logic [EW-1:0]  w_eff;
    logic [RW-1:0]  h_eff;
    logic           in_ok, out_col_end, out_row_end;
    rmf_pkg::t_dec  dec;

    // Clamp the registers to the usable range
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = EW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = RW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(r_cfg_h);
        end
    end

    // Decode the pending transaction against the frame counters
    always_comb begin
        in_ok       = (r_in_row < h_eff) && (EW'(r_in_col) < w_eff);
        out_col_end = (EW'(r_out_col) == w_eff - EW'(1));
        out_row_end = (RW'(r_out_row) == h_eff - RW'(1));

        dec        = '0;
        dec.border = (r_out_row == '0) || (r_out_col == '0) || out_row_end || out_col_end;
        dec.last   = out_row_end && out_col_end;
        dec.row    = rmf_pkg::OUT_ROW_W'(r_out_row);
        dec.col    = rmf_pkg::OUT_COL_W'(r_out_col);
        if (i_action == rmf_pkg::ACT_FLUSH) begin
            dec.emit = (r_in_row >= h_eff);
        end else begin
            dec.write = in_ok;
            // the first width+1 pixels of a frame only prime the window
            dec.emit  = in_ok && ((r_in_row >= RW'(2)) ||
                                  ((r_in_row == RW'(1)) && (r_in_col != '0)));
        end
    end

    // Next counter values
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (dec.write) begin
            if (EW'(r_in_col) == w_eff - EW'(1)) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
        if (dec.emit) begin
            if (out_col_end) begin
                n_out_col = '0;
                n_out_row = r_out_row + ORW'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
        if (dec.emit && dec.last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= rmf_pkg::RESET_WIDTH;
            r_cfg_h   <= rmf_pkg::RESET_HEIGHT;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_we) begin
            // any register write restarts the frame
            unique case (i_cfg_idx)
                rmf_pkg::CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_data[rmf_pkg::CFG_W_W-1:0];
                rmf_pkg::CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_data[rmf_pkg::CFG_H_W-1:0];
                default: ;
            endcase
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_dec = dec;
    assign o_col = r_in_col;

endmodule

/* src/rmf_window.sv */
module rmf_window (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  rmf_pkg::t_pix i_top,
    input  rmf_pkg::t_pix i_mid,
    input  rmf_pkg::t_pix i_pix,
    output rmf_pkg::t_pix o_mean
);

    // Window taps: index = row * 3 + column, column 2 is the newest
    rmf_pkg::t_pix r_win [9];
    rmf_pkg::t_pix n_win [9];
    logic [10:0]   sum_b, sum_g, sum_r;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_win[k] = r_win[k];
        end
        if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                n_win[r*3]     = r_win[r*3 + 1];
                n_win[r*3 + 1] = r_win[r*3 + 2];
            end
            n_win[2] = i_top;
            n_win[5] = i_mid;
            n_win[8] = i_pix;
        end
    end

    // Neighbor sums of the updated window, center tap left out
    always_comb begin
        sum_b = '0;
        sum_g = '0;
        sum_r = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                sum_b = sum_b + {3'd0, n_win[k].blue};
                sum_g = sum_g + {3'd0, n_win[k].green};
                sum_r = sum_r + {3'd0, n_win[k].red};
            end
        end
        o_mean.blue  = rmf_pkg::round_mean8(sum_b);
        o_mean.green = rmf_pkg::round_mean8(sum_g);
        o_mean.red   = rmf_pkg::round_mean8(sum_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_shift) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_W         = 2048;
    localparam int MAX_H         = 4096;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int DRAIN_LIMIT   = 2_000;

    // One filtered output pixel
    typedef struct packed {
        logic [7:0]                    blue;
        logic [7:0]                    green;
        logic [7:0]                    red;
        logic [rmf_pkg::OUT_ROW_W-1:0] row;
        logic [rmf_pkg::OUT_COL_W-1:0] col;
        logic                          fe;
    } t_res;

    // Directed stimulus: fixed result where it is obvious, else predicted
    typedef struct packed {
        logic          act;
        rmf_pkg::t_pix px;
        logic          fixed;
        logic          has;
        t_res          res;
    } t_dir_row;

    // One random phase: register setting and amount of traffic
    typedef struct packed {
        logic        wr_w;
        logic        wr_h;
        logic [12:0] w;
        logic [12:0] h;
        logic [15:0] items;
        logic        hold;
        logic        pause;
    } t_phase;

    typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_TOGGLE} t_rx_mode;

    // 3x3 frame: one interior pixel, blue at max, green/red on rounding ties
    localparam t_dir_row DIR_TBL [0:16] = '{
        '{rmf_pkg::ACT_FLUSH, 24'h000000, 1'b1, 1'b0, '0},
        '{rmf_pkg::ACT_PIXEL, 24'h0301FF, 1'b1, 1'b0, '0},
        '{rmf_pkg::ACT_PIXEL, 24'h0301FF, 1'b1, 1'b0, '0},
        '{rmf_pkg::ACT_PIXEL, 24'h0301FF, 1'b1, 1'b0, '0},
        '{rmf_pkg::ACT_PIXEL, 24'h0301FF, 1'b1, 1'b0, '0},
        '{rmf_pkg::ACT_PIXEL, 24'hFFFFFF, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 12'd0, 11'd0, 1'b0}},
        '{rmf_pkg::ACT_PIXEL, 24'h0000FF, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 12'd0, 11'd1, 1'b0}},
        '{rmf_pkg::ACT_PIXEL, 24'h0000FF, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 12'd0, 11'd2, 1'b0}},
        '{rmf_pkg::ACT_PIXEL, 24'h0000FF, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 12'd1, 11'd0, 1'b0}},
        '{rmf_pkg::ACT_PIXEL, 24'h0000FF, 1'b0, 1'b0, '0},
        '{rmf_pkg::ACT_PIXEL, 24'h123456, 1'b1, 1'b0, '0},
        '{rmf_pkg::ACT_FLUSH, 24'h000000, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 12'd1, 11'd2, 1'b0}},
        '{rmf_pkg::ACT_FLUSH, 24'h000000, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 12'd2, 11'd0, 1'b0}},
        '{rmf_pkg::ACT_FLUSH, 24'h000000, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 12'd2, 11'd1, 1'b0}},
        '{rmf_pkg::ACT_FLUSH, 24'h000000, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 12'd2, 11'd2, 1'b1}},
        '{rmf_pkg::ACT_FLUSH, 24'h000000, 1'b1, 1'b0, '0},
        '{rmf_pkg::ACT_PIXEL, 24'hA5C3E7, 1'b1, 1'b0, '0}
    };

    localparam int N_PHASES = 13;
    localparam t_phase PHASES [0:N_PHASES-1] = '{
        '{1'b1, 1'b1, 13'd4,    13'd4,    16'd50,  1'b0, 1'b1},
        '{1'b1, 1'b1, 13'd1,    13'd1,    16'd30,  1'b0, 1'b0},
        '{1'b1, 1'b1, 13'd0,    13'd0,    16'd20,  1'b0, 1'b0},
        '{1'b1, 1'b1, 13'd2,    13'd5,    16'd40,  1'b0, 1'b0},
        '{1'b1, 1'b1, 13'd5,    13'd2,    16'd40,  1'b0, 1'b0},
        '{1'b1, 1'b1, 13'd7,    13'd6,    16'd90,  1'b1, 1'b0},
        '{1'b1, 1'b1, 13'h1FFF, 13'h1FFF, 16'd40,  1'b0, 1'b0},
        '{1'b1, 1'b1, 13'd2048, 13'd4096, 16'd30,  1'b0, 1'b0},
        '{1'b1, 1'b0, 13'd16,   13'd0,    16'd70,  1'b1, 1'b0},
        '{1'b0, 1'b1, 13'd0,    13'd12,   16'd90,  1'b0, 1'b1},
        '{1'b1, 1'b1, 13'd1,    13'd5000, 16'd50,  1'b0, 1'b0},
        '{1'b1, 1'b1, 13'd3,    13'd3,    16'd40,  1'b1, 1'b0},
        '{1'b1, 1'b1, 13'd6,    13'd5,    16'd60,  1'b0, 1'b1}
    };

    // DUT ports
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic                           i_cfg_idx   = rmf_pkg::CFG_IDX_WIDTH;
    logic [rmf_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    logic                           i_action    = rmf_pkg::ACT_PIXEL;
    logic [7:0]                     i_in_blue   = '0;
    logic [7:0]                     i_in_green  = '0;
    logic [7:0]                     i_in_red    = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [7:0]                     o_out_blue;
    logic [7:0]                     o_out_green;
    logic [7:0]                     o_out_red;
    logic [rmf_pkg::OUT_ROW_W-1:0]  o_out_row;
    logic [rmf_pkg::OUT_COL_W-1:0]  o_out_col;
    logic                           o_frame_end;

    // Filter state mirror
    logic [rmf_pkg::CFG_W_W-1:0] cfg_width  = rmf_pkg::RESET_WIDTH;
    logic [rmf_pkg::CFG_H_W-1:0] cfg_height = rmf_pkg::RESET_HEIGHT;
    rmf_pkg::t_pix               line_above [MAX_W];
    rmf_pkg::t_pix               line_last  [MAX_W];
    rmf_pkg::t_pix               win        [9];
    int unsigned                 in_row, in_col, out_idx;

    // Results owed by the filter, oldest first
    t_res expected_pixels [$];

    int       fail_cnt   = 0;
    int       cycle_cnt  = 0;
    int       burst_left = 0;
    bit       no_gaps    = 1'b0;
    bit       hold_req   = 1'b0;
    int       hold_left  = 0;
    int       mode_left  = 0;
    t_rx_mode rx_mode    = RX_ALWAYS;

    ring_mean_3x3_filter_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_in_blue   (i_in_blue),
        .i_in_green  (i_in_green),
        .i_in_red    (i_in_red),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_frame_end (o_frame_end)
    );

    always #4 i_clk = ~i_clk;

    // Run guard
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned frame_w();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned frame_h();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_H) return MAX_H;
        return cfg_height;
    endfunction

    // Sum of eight bytes over 8, nearest, ties to even
    function automatic logic [7:0] round_eighth(input int unsigned sum);
        int unsigned q;
        int unsigned rem;
        q   = sum >> 3;
        rem = sum % 8;
        if (rem > 4 || (rem == 4 && (q % 2) == 1)) q++;
        return 8'(q);
    endfunction

    // Next output pixel from the current window, advances the output index
    task automatic make_output(input int unsigned w, input int unsigned h, output t_res res);
        int unsigned row, col, sb, sg, sr;
        bit          border;
        row    = out_idx / w;
        col    = out_idx % w;
        border = (row == 0) || (col == 0) || (row == h - 1) || (col == w - 1);
        sb = 0;
        sg = 0;
        sr = 0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                sb += win[k].blue;
                sg += win[k].green;
                sr += win[k].red;
            end
        end
        res.blue  = border ? 8'd0 : round_eighth(sb);
        res.green = border ? 8'd0 : round_eighth(sg);
        res.red   = border ? 8'd0 : round_eighth(sr);
        res.row   = rmf_pkg::OUT_ROW_W'(row);
        res.col   = rmf_pkg::OUT_COL_W'(col);
        res.fe    = (out_idx == w * h - 1);
        out_idx++;
        if (res.fe) begin
            in_row  = 0;
            in_col  = 0;
            out_idx = 0;
        end
    endtask

    // Filter behavior for one transaction; took is low when it is ignored
    task automatic filter_step(input logic act, input rmf_pkg::t_pix px,
                               output bit took, output bit has, output t_res res);
        int unsigned   w, h, c, p;
        rmf_pkg::t_pix top, mid;
        w    = frame_w();
        h    = frame_h();
        took = 1'b0;
        has  = 1'b0;
        res  = '0;
        if (act == rmf_pkg::ACT_FLUSH) begin
            if (in_row >= h && out_idx < w * h) begin
                took = 1'b1;
                has  = 1'b1;
                make_output(w, h, res);
            end
        end else if (in_row < h && in_col < w) begin
            took          = 1'b1;
            c             = in_col;
            top           = line_above[c];
            mid           = line_last[c];
            line_above[c] = mid;
            line_last[c]  = px;
            for (int r = 0; r < 3; r++) begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = px;
            p = in_row * w + in_col;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (p >= w + 1 && out_idx < w * h) begin
                has = 1'b1;
                make_output(w, h, res);
            end
        end
    endtask

    function automatic rmf_pkg::t_pix rand_pix();
        rmf_pkg::t_pix px;
        case ($urandom_range(0, 3))
            0: px = {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                     $urandom_range(0, 1) ? 8'hFF : 8'h00,
                     $urandom_range(0, 1) ? 8'hFF : 8'h00};
            1: px = {8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                     8'($urandom_range(0, 7))};
            default: px = 24'($urandom);
        endcase
        return px;
    endfunction

    // Register write; the filter restarts its frame counters
    task automatic write_reg(input logic idx, input logic [rmf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == rmf_pkg::CFG_IDX_WIDTH) cfg_width = data[rmf_pkg::CFG_W_W-1:0];
        else cfg_height = data[rmf_pkg::CFG_H_W-1:0];
        in_row  = 0;
        in_col  = 0;
        out_idx = 0;
    endtask

    // Offer one transaction and hold it until taken
    task automatic send_txn(input logic act, input rmf_pkg::t_pix px, input bit fixed,
                            input bit fixed_has, input t_res fixed_res, output bit took);
        bit   has;
        t_res res;
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_in_blue  <= px.blue;
        i_in_green <= px.green;
        i_in_red   <= px.red;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        filter_step(act, px, took, has, res);
        if (fixed) begin
            has = fixed_has;
            res = fixed_res;
        end
        if (has) expected_pixels.push_back(res);
    endtask

    // Sender bursts with random gaps in between
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending until every owed result has left the filter
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: changing stall patterns plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = $urandom_range(40, 80);
        end
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 150);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_HALF:   i_out_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: i_out_ready <= ($urandom_range(0, 9) != 0);
                RX_TOGGLE: i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    // Compare each output transaction with the oldest owed result
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_out_blue, o_out_green, o_out_red, o_out_row, o_out_col, o_frame_end};
            if (expected_pixels.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected pixel row %0d col %0d bgr %h %h %h fe %0d",
                             got.row, got.col, got.blue, got.green, got.red, got.fe);
            end else begin
                want = expected_pixels.pop_front();
                if (got.blue !== want.blue || got.green !== want.green ||
                    got.red !== want.red || got.row !== want.row ||
                    got.col !== want.col || got.fe !== want.fe) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("pixel mismatch exp r%0d c%0d bgr %h %h %h fe %0d, %s",
                                 want.row, want.col, want.blue, want.green, want.red,
                                 want.fe, $sformatf("got r%0d c%0d bgr %h %h %h fe %0d",
                                 got.row, got.col, got.blue, got.green, got.red, got.fe));
                end
            end
        end
    end

    // Stimulus
    initial begin
        bit     took;
        bit     held, paused;
        int     done;
        int     waited;
        logic   act;
        t_phase ph;

        for (int i = 0; i < MAX_W; i++) begin
            line_above[i] = '0;
            line_last[i]  = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        in_row  = 0;
        in_col  = 0;
        out_idx = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed 3x3 frame
        write_reg(rmf_pkg::CFG_IDX_WIDTH, 13'd3);
        write_reg(rmf_pkg::CFG_IDX_HEIGHT, 13'd3);
        i_cfg_we <= 1'b0;
        for (int i = 0; i < 17; i++) begin
            send_txn(DIR_TBL[i].act, DIR_TBL[i].px, DIR_TBL[i].fixed,
                     DIR_TBL[i].has, DIR_TBL[i].res, took);
            pace();
        end

        // Random phases, mostly well-formed frames with some noise
        for (int n = 0; n < N_PHASES; n++) begin
            ph = PHASES[n];
            drain();
            if (ph.wr_w) write_reg(rmf_pkg::CFG_IDX_WIDTH, ph.w);
            if (ph.wr_h) write_reg(rmf_pkg::CFG_IDX_HEIGHT, ph.h);
            i_cfg_we <= 1'b0;
            no_gaps = ($urandom_range(0, 3) == 0);
            done    = 0;
            held    = 1'b0;
            paused  = 1'b0;
            while (done < ph.items) begin
                if (in_row < frame_h())
                    act = ($urandom_range(0, 9) == 0) ? rmf_pkg::ACT_FLUSH
                                                      : rmf_pkg::ACT_PIXEL;
                else
                    act = ($urandom_range(0, 6) == 0) ? rmf_pkg::ACT_PIXEL
                                                      : rmf_pkg::ACT_FLUSH;
                send_txn(act, rand_pix(), 1'b0, 1'b0, '0, took);
                if (took) done++;
                if (ph.hold && !held && done >= ph.items / 3) begin
                    // output held off while the input keeps coming
                    held       = 1'b1;
                    hold_req   = 1'b1;
                    burst_left = 50;
                end
                if (ph.pause && !paused && done >= ph.items / 2) begin
                    paused = 1'b1;
                    drain();
                end
                pace();
            end
        end

        // Wait for the tail, bounded
        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("%0d expected pixels never arrived", expected_pixels.size());
        end

        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
